FILE: src/mopf_pkg.sv
`default_nettype none

package mopf_pkg;

    // Field widths
    localparam int PIX_W = 8;
    localparam int DIM_W = 11;
    localparam int ROW_W = 10;

    // Frame size limits and reset values
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int DIM_MIN       = 3;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;

    // Decision constants
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
    localparam logic [PIX_W-1:0] DIFF_LIMIT = 8'd128;

    // Register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/mean_outlier_pixel_filter.sv
// Latency: a result is registered at the edge that accepts the item causing it and shows
//   on o_out_valid in the next cycle; pixel (r,c) comes out with pixel (r+1,c+1) or a flush.
// Throughput: one request per cycle while not stalled, set by the single registered
//   window pass and one read plus one write per cycle on each of the two line buffers.
// Reset: synchronous, active low; clears counters and output valid, presets size registers.
//   Line buffers are not cleared; during the first row an entry can be read before it is written.
`default_nettype none

module mean_outlier_pixel_filter #(
    parameter int MAX_WIDTH = mopf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire mopf_pkg::t_in_item            i_in_data,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mopf_pkg::t_out_item                o_out_data,
    // Register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mopf_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mopf_pkg::DATA_W-1:0]   pwdata,
    output logic [mopf_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import mopf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = $clog2(MAX_WIDTH + 2);
    localparam int XW    = (WW > DIM_W) ? WW : DIM_W;
    localparam int SUM_W = PIX_W + 3;
    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    // Size registers, as written and as clamped
    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [WW-1:0]    r_eff_w;
    logic [DIM_W-1:0] r_eff_h;

    // Receive and emit positions
    logic [CW-1:0]    r_rx_col;
    logic [ROW_W-1:0] r_rx_row;
    logic             r_rx_done;
    logic [PW-1:0]    r_pending;
    logic [CW-1:0]    r_e_col;
    logic [ROW_W-1:0] r_e_row;

    // Window: filtered row above, filtered left, raw center/right, raw row below
    logic [PIX_W-1:0] r_up0, r_up1, r_up2;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_center, r_right;
    logic [PIX_W-1:0] r_dn1, r_dn2;

    // Line buffers: raw pixels and filtered results, one row each
    logic [PIX_W-1:0] r_raw_line  [MAX_WIDTH];
    logic [PIX_W-1:0] r_filt_line [MAX_WIDTH];

    logic             r_out_valid;
    t_out_item        r_out;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [XW-1:0]        wv;
    logic [WW-1:0]        n_eff_w;
    logic [DIM_W-1:0]     hv;
    logic [DIM_W-1:0]     n_eff_h;

    logic             in_go, is_flush, pix_go, full, emit_pix, emit_flush, emit, advance;
    logic             e_col_end, e_row_end, rx_col_end, rx_row_end, interior, last;
    logic [CW-1:0]    n_rx_col;
    logic [WW:0]      fa_sum;
    logic [CW-1:0]    filt_addr;
    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] mean, diff, n_pix_out;

    // Register port decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
        endcase
    end

    // Clamp written sizes into the legal range
    always_comb begin
        wv = XW'(pwdata[DIM_W-1:0]);
        if (wv < XW'(DIM_MIN)) begin
            wv = XW'(DIM_MIN);
        end else if (wv > XW'(MAX_WIDTH)) begin
            wv = XW'(MAX_WIDTH);
        end
        n_eff_w = WW'(wv);

        hv = pwdata[DIM_W-1:0];
        if (hv < DIM_W'(DIM_MIN)) begin
            hv = DIM_W'(DIM_MIN);
        end else if (hv > DIM_W'(HEIGHT_LIMIT)) begin
            hv = DIM_W'(HEIGHT_LIMIT);
        end
        n_eff_h = hv;
    end

    // Handshake: the result register parts the two sides
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_go      = i_in_valid && !o_in_stall;
    assign is_flush   = (i_in_data.mode == MODE_FLUSH);
    assign pix_go     = in_go && !is_flush && !r_rx_done;
    assign full       = (r_pending == (PW'(r_eff_w) + PW'(1)));
    assign emit_pix   = pix_go && full;
    assign emit_flush = in_go && is_flush && r_rx_done && (r_pending != '0);
    assign emit       = emit_pix || emit_flush;
    assign advance    = pix_go || emit_flush;

    // Position compares
    assign e_col_end  = (WW'(r_e_col) == r_eff_w - WW'(1));
    assign e_row_end  = (DIM_W'(r_e_row) == r_eff_h - DIM_W'(1));
    assign rx_col_end = (WW'(r_rx_col) == r_eff_w - WW'(1));
    assign rx_row_end = (DIM_W'(r_rx_row) == r_eff_h - DIM_W'(1));
    assign last       = e_row_end && e_col_end;
    assign interior   = (r_e_row != '0) && !e_row_end && (r_e_col != '0) && !e_col_end;
    assign n_rx_col   = rx_col_end ? '0 : r_rx_col + CW'(1);

    // Filtered-row prefetch: two columns ahead of the one emitted now
    always_comb begin
        fa_sum = (WW+1)'(r_e_col) + (WW+1)'(2);
        if (fa_sum >= (WW+1)'(r_eff_w)) begin
            fa_sum = fa_sum - (WW+1)'(r_eff_w);
        end
        filt_addr = CW'(fa_sum);
    end

    // Neighborhood mean and outlier decision
    always_comb begin
        sum = SUM_W'(r_up0) + SUM_W'(r_up1) + SUM_W'(r_up2) + SUM_W'(r_left)
            + SUM_W'(r_right) + SUM_W'(r_dn1) + SUM_W'(r_dn2) + SUM_W'(i_in_data.pixel_in);
        mean = sum[SUM_W-1:3];
        diff = (mean >= r_center) ? mean - r_center : r_center - mean;
        n_pix_out = (interior && (diff >= DIFF_LIMIT)) ? PIX_MAX : r_center;
    end

    // Control state: sizes, counters, left result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(WIDTH_RST);
            r_frame_height <= DIM_W'(HEIGHT_RST);
            r_eff_w        <= WW'(W_RST);
            r_eff_h        <= DIM_W'(HEIGHT_RST);
            r_rx_col       <= '0;
            r_rx_row       <= '0;
            r_rx_done      <= 1'b0;
            r_pending      <= '0;
            r_e_col        <= '0;
            r_e_row        <= '0;
            r_left         <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[DIM_W-1:0];
                    r_eff_w       <= n_eff_w;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[DIM_W-1:0];
                    r_eff_h        <= n_eff_h;
                end
            endcase
            // drop the frame in progress
            r_rx_col  <= '0;
            r_rx_row  <= '0;
            r_rx_done <= 1'b0;
            r_pending <= '0;
            r_e_col   <= '0;
            r_e_row   <= '0;
            r_left    <= '0;
        end else if (emit && last) begin
            // restart after the frame's last pixel
            r_rx_col  <= '0;
            r_rx_row  <= '0;
            r_rx_done <= 1'b0;
            r_pending <= '0;
            r_e_col   <= '0;
            r_e_row   <= '0;
            r_left    <= '0;
        end else begin
            // advance the receive position
            if (pix_go) begin
                r_rx_col <= n_rx_col;
                if (rx_col_end) begin
                    if (rx_row_end) begin
                        r_rx_done <= 1'b1;
                    end else begin
                        r_rx_row <= r_rx_row + ROW_W'(1);
                    end
                end
            end else if (emit_flush) begin
                r_rx_col <= n_rx_col;
            end

            // count pixels held back
            if (pix_go && !full) begin
                r_pending <= r_pending + PW'(1);
            end else if (emit_flush) begin
                r_pending <= r_pending - PW'(1);
            end

            // advance the emit position
            if (emit) begin
                r_left <= n_pix_out;
                if (e_col_end) begin
                    r_e_col <= '0;
                    r_e_row <= r_e_row + ROW_W'(1);
                end else begin
                    r_e_col <= r_e_col + CW'(1);
                end
            end
        end
    end

    // Raw line buffer and raw window taps
    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_raw_line[r_rx_col] <= i_in_data.pixel_in;
            r_dn1 <= i_in_data.pixel_in;
            r_dn2 <= r_dn1;
        end
        if (advance) begin
            r_center <= r_right;
            r_right  <= r_raw_line[n_rx_col];
        end
    end

    // Filtered line buffer and upper window taps
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_filt_line[r_e_col] <= n_pix_out;
            r_up0 <= r_filt_line[filt_addr];
            r_up1 <= r_up0;
            r_up2 <= r_up1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.pixel_out  <= n_pix_out;
            r_out.frame_last <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: src/mopf_checker.sv
`default_nettype none

module mopf_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire mopf_pkg::t_out_item o_out_data
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result held by the receiver keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // A full, stalled result register blocks new requests
    a_back_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request taken while result register blocked");

    // No result appears without an accepted request
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result without request");

endmodule

bind mean_outlier_pixel_filter mopf_checker u_mopf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
